/* src/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted insert priority queue
// Entry, link and command structs that pass between the queue cells and the
// top level, plus the command and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int unsigned KEY_W        = 16;
    localparam int unsigned VAL_W        = 16;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned DATA_W       = KEY_W + VAL_W;
    localparam int unsigned QUEUE_DEPTH_DEF = 32;

    // command codes (input tuser)
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    // status codes (output tuser)
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    // what a cell shows its right-hand neighbor
    typedef struct packed {
        t_entry ent;
        logic   place;   // new key belongs at or left of this cell
    } t_link;

    // broadcast to every cell
    typedef struct packed {
        logic             en;
        logic             take;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cmd;

endpackage

/* src/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor; on take it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_link  i_left,
    input  t_entry i_right,
    output t_link  o_link
);

    logic             r_vld;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    t_entry           n_ent;
    logic             w_place;
    logic             w_load;

    // first slot that is empty or holds a strictly greater key takes the entry
    assign w_place = !r_vld || (r_key > i_cmd.key);

    always_comb begin
        n_ent  = '{valid: r_vld, key: r_key, value: r_val};
        w_load = 1'b0;
        if (i_cmd.en) begin
            if (i_cmd.take) begin
                n_ent  = i_right;
                w_load = 1'b1;
            end else if (w_place) begin
                w_load = 1'b1;
                if (i_left.place) begin
                    n_ent = i_left.ent;
                end else begin
                    n_ent = '{valid: 1'b1, key: i_cmd.key, value: i_cmd.value};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= n_ent.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key <= n_ent.key;
            r_val <= n_ent.value;
        end
    end

    assign o_link.ent   = '{valid: r_vld, key: r_key, value: r_val};
    assign o_link.place = w_place;

endmodule

/* src/sorted_insert_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_unit: bounded stable priority queue
// Row of QUEUE_DEPTH cells kept in ascending key order, one result per command.
// ----------------------------------------------------------------------------
// The queue takes one transaction per clock cycle while input tready is high.
// Each transaction is an insert (tuser = 0) or a take-first (tuser = 1) and
// yields exactly one result transaction through a single output register,
// so a command may enter in every cycle as long as the output side keeps up;
// input tready drops only while that register holds a result not yet taken.
// The rate is set by the cell row: every cell compares its key with the
// broadcast key in the same cycle, and the cells from the insertion point on
// (all cells on a take) shift by one place, so insert and take cost the same
// whatever the fill level. Equal keys keep arrival order. Insert into a full
// queue is dropped with status full; take from an empty queue returns status
// empty. head_key and head_value are zero unless a take removed an entry.
module sorted_insert_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [DATA_W-1:0]   i_s_tdata,   // [15:0] key, [31:16] value
    input  logic                i_s_tuser,   // [0] command
    // result stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [DATA_W-1:0]   o_m_tdata,   // [15:0] head_key, [31:16] head_value
    output logic [STATUS_W-1:0] o_m_tuser    // [1:0] status
);

    t_link  w_link [QUEUE_DEPTH];
    t_link  w_left [QUEUE_DEPTH];
    t_entry w_right[QUEUE_DEPTH];
    t_cmd   w_cmd;

    logic   w_acc;
    logic   w_full;
    logic   w_empty;
    logic   w_take;

    logic                r_out_vld;
    logic [DATA_W-1:0]   r_out_data;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   n_out_data;
    logic [STATUS_W-1:0] n_out_status;

    // accept when the result register is free or drains this cycle
    assign o_s_tready = !r_out_vld || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_take     = (i_s_tuser == CMD_TAKE);

    // fill level is the thermometer of valid bits: ends of the row tell all
    assign w_full  = w_link[QUEUE_DEPTH-1].ent.valid;
    assign w_empty = !w_link[0].ent.valid;

    // broadcast; drop inserts when full and takes when empty
    always_comb begin
        w_cmd.en    = w_acc && (w_take ? !w_empty : !w_full);
        w_cmd.take  = w_take;
        w_cmd.key   = i_s_tdata[KEY_W-1:0];
        w_cmd.value = i_s_tdata[DATA_W-1:KEY_W];
    end

    // neighbor wiring: head sees no left neighbor, tail shifts in an empty slot
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left[g] = '0;
            end else begin : g_mid
                assign w_left[g] = w_link[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right[g] = '0;
            end else begin : g_body
                assign w_right[g] = w_link[g+1].ent;
            end

            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_link  (w_link[g])
            );
        end
    endgenerate

    // result of the accepted command
    always_comb begin
        n_out_data   = '0;
        n_out_status = ST_DONE;
        if (w_take) begin
            if (w_empty) begin
                n_out_status = ST_EMPTY;
            end else begin
                n_out_data = {w_link[0].ent.value, w_link[0].ent.key};
            end
        end else if (w_full) begin
            n_out_status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_acc) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // hold the payload until a new transaction replaces it
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

`ifndef SYNTH
    logic [QUEUE_DEPTH-1:0] w_vld_vec;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_vld
            assign w_vld_vec[g] = w_link[g].ent.valid;
        end
    endgenerate

    // occupied slots always form a contiguous run from the head
    a_thermometer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld_vec & (w_vld_vec + 1'b1)) == '0)
        else $error("queue cells not contiguous");

    // a successful insert grows the queue by one
    a_insert_grow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_take && !w_full) |=>
        ($countones(w_vld_vec) == $countones($past(w_vld_vec)) + 1))
        else $error("insert did not add an entry");

    // a successful take shrinks the queue by one
    a_take_shrink : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_take && !w_empty) |=>
        ($countones(w_vld_vec) + 1 == $countones($past(w_vld_vec))))
        else $error("take did not remove an entry");

    // a non-done status carries no entry
    a_status_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status != ST_DONE) |-> (r_out_data == '0))
        else $error("failed command returned data");
`endif

endmodule
